@@ design/oept_pkg.sv @@
// ----------------------------------------------------------------------------
// Oscillation extremum phase tracker package
// Widths and constants for the phase tracker.
// ----------------------------------------------------------------------------
package oept_pkg;

	localparam int PITCH_W = 16;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int OUT_W   = 21;

	// Intermediate widths of the estimate datapath.
	localparam int X_W     = PITCH_W + 2;
	localparam int D_W     = PITCH_W + 1;
	localparam int PROD_W  = X_W + CFG_W + 1;
	localparam int MAG_W   = PROD_W - 1;
	localparam int DVD_W   = MAG_W + 2;
	localparam int DIV_W   = D_W + 1;
	localparam int QUO_W   = OUT_W;
	localparam int CNT_W   = $clog2(QUO_W);

	// Guard time is ceil(period / 3), taken as floor((period + 2) * RECIP >> SHIFT).
	localparam int GUARD_SHIFT = 17;
	localparam logic [CFG_W-1:0] GUARD_RECIP = 16'd43691;
	localparam int GUARD_PROD_W = CFG_W + 1 + CFG_W;

	localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd10000;
	localparam logic [CFG_W-1:0] SETTLE_RESET = 16'd500;
	localparam logic [CFG_W-1:0] GUARD_RESET  = 16'd3334;

	localparam logic [OUT_W-1:0] EST_MAX  = 21'h0F_FFFF;
	localparam logic [OUT_W-1:0] EST_MIN  = 21'h10_0000;
	localparam logic [OUT_W-1:0] EST_NONE = 21'h1F_FFFF;

	localparam int ADDR_W = 3;
	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_SETTLE = 1'b1;

endpackage

@@ design/oscillation_extremum_phase_tracker.sv @@
// ----------------------------------------------------------------------------
// Oscillation extremum phase tracker
// Tracks alternate pitch minima and maxima and estimates the time until the
// next maximum from a triangular model of the oscillation.
// ----------------------------------------------------------------------------
// Each input item carries a pitch sample and its millisecond timestamp. The
// block updates its running extremum, locks it when both the guard time and
// the settle time have passed, and returns one result item per input item:
// the estimated time to the next maximum, its validity, the search direction
// and both locked extremes.
// An item passes from its acceptance through an update step, four set-up
// steps around one 17 by 18 bit multiplier, 21 steps of a restoring
// divider, one quotient bit per cycle, and the output step. When no
// estimate can be made the divider is skipped. The next item is accepted
// only after the result of the last one is offered, so the block does not
// take a new item while one is being worked on.
// in_stall is high while an item is being worked on. A finished result waits
// in the output register while out_stall is high; a new item may be accepted
// meanwhile, but its result waits until the previous one has been taken.
// The two configuration registers are written through the APB-style port at
// byte addresses 0 and 4. Reset leaves the period at 10000 ms, the settle
// time at 500 ms, the search set to look for a minimum and all extremes clear.
// ----------------------------------------------------------------------------
module oscillation_extremum_phase_tracker
	import oept_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [PITCH_W-1:0] pitch,
	input  logic [TIME_W-1:0]        now_ms,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OUT_W-1:0]  time_to_max_ms,
	output logic                     estimate_valid,
	output logic                     pitching_backward,
	output logic signed [PITCH_W-1:0] locked_min,
	output logic signed [PITCH_W-1:0] locked_max
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_OPS,
		S_MUL,
		S_PREP,
		S_CHK,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] period_q;
	logic [CFG_W-1:0] settle_q;
	logic [CFG_W-1:0] guard_q;

	logic signed [PITCH_W-1:0] pitch_q;
	logic [TIME_W-1:0]         now_q;

	logic                      seek_min_q;
	logic signed [PITCH_W-1:0] run_q;
	logic signed [PITCH_W-1:0] held_min_q;
	logic signed [PITCH_W-1:0] held_max_q;
	logic [TIME_W-1:0]         min_stamp_q;
	logic [TIME_W-1:0]         max_stamp_q;
	logic                      min_seen_q;
	logic                      max_seen_q;

	logic signed [X_W-1:0]     x_q;
	logic signed [D_W-1:0]     d_q;
	logic                      est_ok_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      neg_q;
	logic [DVD_W-1:0]          dvd_q;
	logic [DIV_W-1:0]          divisor_q;
	logic                      ovf_q;
	logic [DIV_W-1:0]          rem_q;
	logic [QUO_W-1:0]          quo_q;
	logic [CNT_W-1:0]          cnt_q;

	logic cfg_wr;
	logic [GUARD_PROD_W-1:0] guard_prod;
	logic [TIME_W-1:0] since_min;
	logic [TIME_W-1:0] since_max;
	logic lock_min;
	logic lock_max;
	logic signed [X_W-1:0] hmax_x;
	logic signed [X_W-1:0] hmin_x;
	logic signed [X_W-1:0] p_x;
	logic signed [X_W-1:0] x_next;
	logic signed [D_W-1:0] d_next;
	logic [MAG_W-1:0] n_mag;
	logic [D_W-2:0] d_mag;
	logic [DIV_W:0] div_trial;
	logic div_ge;
	logic [DIV_W:0] div_diff;
	logic [QUO_W-1:0] quo_lim;
	logic [OUT_W-1:0] est;
	logic out_free;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign guard_prod = ({1'b0, pwdata[CFG_W-1:0]} + (CFG_W+1)'(2)) * GUARD_RECIP;

	always_comb begin
		case (paddr[2])
			REG_PERIOD: prdata = {{(32-CFG_W){1'b0}}, period_q};
			REG_SETTLE: prdata = {{(32-CFG_W){1'b0}}, settle_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			settle_q <= SETTLE_RESET;
			guard_q  <= GUARD_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_PERIOD) begin
				period_q <= pwdata[CFG_W-1:0];
				guard_q  <= guard_prod[GUARD_SHIFT +: CFG_W];
			end else begin
				settle_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	assign since_min = now_q - min_stamp_q;
	assign since_max = now_q - max_stamp_q;
	assign lock_min = (since_max >= {{(TIME_W-CFG_W){1'b0}}, guard_q}) &&
		(since_min >= {{(TIME_W-CFG_W){1'b0}}, settle_q});
	assign lock_max = (since_min >= {{(TIME_W-CFG_W){1'b0}}, guard_q}) &&
		(since_max >= {{(TIME_W-CFG_W){1'b0}}, settle_q});

	assign hmax_x = X_W'(held_max_q);
	assign hmin_x = X_W'(held_min_q);
	assign p_x    = X_W'(pitch_q);
	assign x_next = seek_min_q ? (hmax_x - (hmin_x <<< 1) + p_x) : (hmax_x - p_x);
	assign d_next = D_W'(held_max_q) - D_W'(held_min_q);

	assign n_mag = prod_q[PROD_W-1] ? MAG_W'(-prod_q) : MAG_W'(prod_q);
	assign d_mag = d_q[D_W-1] ? (D_W-1)'(-d_q) : (D_W-1)'(d_q);

	assign div_trial = {rem_q, quo_q[QUO_W-1]};
	assign div_ge    = div_trial >= {1'b0, divisor_q};
	assign div_diff  = div_trial - {1'b0, divisor_q};

	assign quo_lim = neg_q ? EST_MIN : EST_MAX;

	always_comb begin
		if (!est_ok_q) begin
			est = EST_NONE;
		end else if (ovf_q || (quo_q > quo_lim)) begin
			est = neg_q ? EST_MIN : EST_MAX;
		end else begin
			est = neg_q ? (~quo_q + 1'b1) : quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			pitch_q           <= '0;
			now_q             <= '0;
			seek_min_q        <= 1'b1;
			run_q             <= '0;
			held_min_q        <= '0;
			held_max_q        <= '0;
			min_stamp_q       <= '0;
			max_stamp_q       <= '0;
			min_seen_q        <= 1'b0;
			max_seen_q        <= 1'b0;
			x_q               <= '0;
			d_q               <= '0;
			est_ok_q          <= 1'b0;
			prod_q            <= '0;
			neg_q             <= 1'b0;
			dvd_q             <= '0;
			divisor_q         <= '0;
			ovf_q             <= 1'b0;
			rem_q             <= '0;
			quo_q             <= '0;
			out_valid         <= 1'b0;
			time_to_max_ms    <= '0;
			estimate_valid    <= 1'b0;
			pitching_backward <= 1'b0;
			locked_min        <= '0;
			locked_max        <= '0;
			cnt_q             <= '0;
		end else begin
			if (out_valid && !out_stall && (state_q != S_DONE)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pitch_q <= pitch;
						now_q   <= now_ms;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (seek_min_q) begin
						if (pitch_q < run_q) begin
							run_q       <= pitch_q;
							min_stamp_q <= now_q;
							min_seen_q  <= 1'b1;
						end else if (lock_min) begin
							held_min_q <= run_q;
							seek_min_q <= 1'b0;
						end
					end else begin
						if (pitch_q > run_q) begin
							run_q       <= pitch_q;
							max_stamp_q <= now_q;
							max_seen_q  <= 1'b1;
						end else if (lock_max) begin
							held_max_q <= run_q;
							seek_min_q <= 1'b1;
						end
					end
					state_q <= S_OPS;
				end
				S_OPS: begin
					x_q      <= x_next;
					d_q      <= d_next;
					est_ok_q <= min_seen_q && max_seen_q && (held_max_q != held_min_q);
					state_q  <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= $signed({1'b0, period_q}) * x_q;
					state_q <= S_PREP;
				end
				S_PREP: begin
					neg_q     <= prod_q[PROD_W-1] ^ d_q[D_W-1];
					dvd_q     <= {1'b0, n_mag, 1'b0} + DVD_W'({d_mag, 1'b0});
					divisor_q <= {d_mag, 2'b00};
					state_q   <= S_CHK;
				end
				S_CHK: begin
					ovf_q   <= ({3'b000, dvd_q} >= {divisor_q, {QUO_W{1'b0}}});
					rem_q   <= DIV_W'(dvd_q[DVD_W-1:QUO_W]);
					quo_q   <= dvd_q[QUO_W-1:0];
					cnt_q   <= CNT_W'(QUO_W - 1);
					state_q <= est_ok_q ? S_DIV : S_DONE;
				end
				S_DIV: begin
					rem_q <= div_ge ? div_diff[DIV_W-1:0] : div_trial[DIV_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], div_ge};
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid         <= 1'b1;
						time_to_max_ms    <= est;
						estimate_valid    <= est_ok_q;
						pitching_backward <= seek_min_q;
						locked_min        <= held_min_q;
						locked_max        <= held_max_q;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/oscillation_extremum_phase_tracker_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Oscillation extremum phase tracker testbench
// Drives timestamped pitch samples into the tracker under random bursts and
// output stalls, predicts every result item from its own copy of the tracker
// state and compares each result field by field, in order. Directed items
// cover the field extremes, timestamp wrap and reversal, equal extremes,
// saturation and zero registers; random items follow noisy triangle waves
// under several register settings, with pure noise mixed in.
// ----------------------------------------------------------------------------
module oscillation_extremum_phase_tracker_tb;
	import oept_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int HOLD_CYCLES   = 300;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

	typedef struct {
		logic signed [OUT_W-1:0]   ttm;
		logic                      ev;
		logic                      pb;
		logic signed [PITCH_W-1:0] lmin;
		logic signed [PITCH_W-1:0] lmax;
	} estimate_t;

	logic                      clk     = 1'b0;
	logic                      arst_n  = 1'b0;
	logic                      psel    = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite  = 1'b0;
	logic [ADDR_W-1:0]         paddr   = '0;
	logic [31:0]               pwdata  = '0;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic signed [PITCH_W-1:0] pitch    = '0;
	logic [TIME_W-1:0]         now_ms   = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [OUT_W-1:0]   time_to_max_ms;
	logic                      estimate_valid;
	logic                      pitching_backward;
	logic signed [PITCH_W-1:0] locked_min;
	logic signed [PITCH_W-1:0] locked_max;

	logic [CFG_W-1:0]          cfg_period   = PERIOD_RESET;
	logic [CFG_W-1:0]          cfg_settle   = SETTLE_RESET;
	logic                      trk_seek_min = 1'b1;
	logic signed [PITCH_W-1:0] trk_running  = '0;
	logic signed [PITCH_W-1:0] trk_min      = '0;
	logic signed [PITCH_W-1:0] trk_max      = '0;
	logic [TIME_W-1:0]         trk_min_at   = '0;
	logic [TIME_W-1:0]         trk_max_at   = '0;
	logic                      trk_min_seen = 1'b0;
	logic                      trk_max_seen = 1'b0;

	estimate_t pending_estimates[$];
	int        mismatches  = 0;
	int        cycle_count = 0;
	bit        hold_req    = 1'b0;
	int        hold_left   = 0;
	rx_mode_t  rx_mode     = RX_FREE;
	int        rx_left     = 0;
	int        burst_left  = 0;

	oscillation_extremum_phase_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .pitch(pitch), .now_ms(now_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.time_to_max_ms(time_to_max_ms), .estimate_valid(estimate_valid),
		.pitching_backward(pitching_backward),
		.locked_min(locked_min), .locked_max(locked_max)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic estimate_t track_pitch_sample(input logic signed [PITCH_W-1:0] p,
		input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] since_min;
		logic [TIME_W-1:0] since_max;
		logic [TIME_W-1:0] guard;
		longint            hmin, hmax, num, den, mag_n, mag_d, q;
		estimate_t         r;
		since_min = now - trk_min_at;
		since_max = now - trk_max_at;
		guard = (TIME_W'(cfg_period) + 2) / 3;
		if (trk_seek_min) begin
			if (p < trk_running) begin
				trk_running = p;
				trk_min_at = now;
				trk_min_seen = 1'b1;
			end else if (since_max >= guard && since_min >= TIME_W'(cfg_settle)) begin
				trk_min = trk_running;
				trk_seek_min = 1'b0;
			end
		end else begin
			if (p > trk_running) begin
				trk_running = p;
				trk_max_at = now;
				trk_max_seen = 1'b1;
			end else if (since_min >= guard && since_max >= TIME_W'(cfg_settle)) begin
				trk_max = trk_running;
				trk_seek_min = 1'b1;
			end
		end
		r.ttm = EST_NONE;
		r.ev = 1'b0;
		if (trk_min_seen && trk_max_seen && trk_max != trk_min) begin
			hmin = trk_min;
			hmax = trk_max;
			den = 2 * (hmax - hmin);
			num = trk_seek_min ? longint'(cfg_period) * (hmax - 2 * hmin + p)
			                   : longint'(cfg_period) * (hmax - p);
			mag_n = (num < 0) ? -num : num;
			mag_d = (den < 0) ? -den : den;
			q = (2 * mag_n + mag_d) / (2 * mag_d);
			if ((num < 0) != (den < 0))
				r.ttm = (q > longint'(EST_MAX) + 1) ? EST_MIN : OUT_W'(-q);
			else
				r.ttm = (q > longint'(EST_MAX)) ? EST_MAX : OUT_W'(q);
			r.ev = 1'b1;
		end
		r.pb = trk_seek_min;
		r.lmin = trk_min;
		r.lmax = trk_max;
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		estimate_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_estimates.size() == 0) begin
				$display("%0t: unexpected result item, expected none, got time_to_max_ms %0d",
					$time, time_to_max_ms);
				mismatches++;
			end else begin
				want = pending_estimates.pop_front();
				check_field("time_to_max_ms", want.ttm, time_to_max_ms);
				check_field("estimate_valid", want.ev, estimate_valid);
				check_field("pitching_backward", want.pb, pitching_backward);
				check_field("locked_min", want.lmin, locked_min);
				check_field("locked_max", want.lmax, locked_max);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_FREE:  out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HALF:  out_stall <= $urandom_range(0, 1);
				default:  out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic send_item(input logic signed [PITCH_W-1:0] p, input logic [TIME_W-1:0] t);
		in_valid <= 1'b1;
		pitch <= p;
		now_ms <= t;
		do @(posedge clk); while (in_stall);
		pending_estimates.push_back(track_pitch_sample(p, t));
		@(negedge clk);
	endtask

	task automatic send_paced(input logic signed [PITCH_W-1:0] p, input logic [TIME_W-1:0] t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		send_item(p, t);
	endtask

	task automatic wait_for_results;
		in_valid <= 1'b0;
		while (pending_estimates.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel <= 1'b1;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
		logic [31:0] rd;
		apb_access(1'b1, idx, 32'(value), rd);
		if (idx == REG_PERIOD)
			cfg_period = value;
		else
			cfg_settle = value;
		apb_access(1'b0, idx, '0, rd);
		if (rd[CFG_W-1:0] != value) begin
			$display("%0t: register %0d readback expected %0d, got %0d",
				$time, idx, value, rd[CFG_W-1:0]);
			mismatches++;
		end
	endtask

	task automatic configure(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] settle);
		wait_for_results;
		write_register(REG_PERIOD, period);
		write_register(REG_SETTLE, settle);
	endtask

	// Walks the lock sequence through both pitch extremes, equal extremes,
	// the timestamp wrap and timestamps that run backward.
	task automatic test_field_extremes;
		send_item(-32768, 32'd0);
		send_item(0, 32'd400);
		configure(16'd3, 16'd1);
		send_item(0, 32'd402);
		send_item(32767, 32'd404);
		send_item(0, 32'd406);
		send_item(32767, 32'd408);
		send_item(-32768, 32'hFFFF_FFFF);
		send_item(-100, 32'hFFFF_FFFF);
		send_item(0, 32'd3);
		send_item(50, 32'd2);
		send_item(50, 32'd1);
	endtask

	task automatic test_saturation;
		configure(16'hFFFF, 16'hFFFF);
		send_item(32767, 32'd10);
		send_item(-32768, 32'd20);
		send_item(0, 32'd65554);
		send_item(0, 32'd65555);
		send_item(32767, 32'd65556);
	endtask

	task automatic test_zero_registers;
		configure(16'd0, 16'd0);
		send_item(32767, 32'd65556);
		send_item(-5, 32'd65556);
		send_item(-5, 32'd65556);
		send_item(100, 32'd7);
	endtask

	task automatic test_oscillation(input logic [CFG_W-1:0] period,
		input logic [CFG_W-1:0] settle, input int osc, input int count);
		longint            amp, centre, ph, dt_base, dt, val, noise_amp;
		logic [TIME_W-1:0] t;
		configure(period, settle);
		amp = $urandom_range(200, 32767);
		centre = longint'($urandom_range(0, int'(65534 - 2 * amp))) - (32767 - amp);
		noise_amp = amp / 40 + 1;
		t = $urandom;
		ph = $urandom_range(0, osc - 1);
		dt_base = osc / $urandom_range(8, 40) + 1;
		for (int i = 0; i < count; i++) begin
			dt = dt_base + $urandom_range(0, int'(dt_base / 4));
			ph = (ph + dt) % osc;
			t = t + TIME_W'(dt);
			val = centre + ((2 * ph < osc) ? amp - 4 * amp * ph / osc
			                               : 4 * amp * ph / osc - 3 * amp);
			val = val + longint'($urandom_range(0, int'(2 * noise_amp))) - noise_amp;
			if (val > 32767) val = 32767;
			if (val < -32768) val = -32768;
			if ($urandom_range(0, 24) == 0) begin
				if ($urandom_range(0, 1) == 0)
					val = longint'($signed(PITCH_W'($urandom)));
				else
					t = t - TIME_W'($urandom_range(1, 5000));
			end
			send_paced(PITCH_W'(val), t);
		end
	endtask

	task automatic test_random_settings(input int phases);
		int period, settle, osc;
		for (int i = 0; i < phases; i++) begin
			period = $urandom_range(1, 65535);
			settle = $urandom_range(0, period / 4);
			osc = period * $urandom_range(80, 120) / 100 + 20;
			test_oscillation(CFG_W'(period), CFG_W'(settle), osc, 25);
		end
	endtask

	task automatic test_noise(input int count);
		logic [TIME_W-1:0] t;
		configure(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom_range(0, 3000)));
		t = $urandom;
		for (int i = 0; i < count; i++) begin
			t = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom) : t + $urandom_range(0, 3000);
			send_paced(PITCH_W'($urandom), t);
		end
	endtask

	// The receiver holds off while items keep coming, so the tracker fills
	// up and has to stall its input.
	task automatic test_output_holdoff;
		logic [TIME_W-1:0] t;
		configure(16'd600, 16'd40);
		t = $urandom;
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++) begin
			t = t + $urandom_range(20, 200);
			send_item(PITCH_W'($urandom), t);
		end
	endtask

	task automatic test_sender_pause;
		logic [TIME_W-1:0] t;
		configure(16'd900, 16'd60);
		t = $urandom;
		for (int i = 0; i < 40; i++) begin
			if (i == 20)
				wait_for_results;
			t = t + $urandom_range(10, 300);
			send_paced(PITCH_W'($urandom), t);
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_field_extremes;
		test_saturation;
		test_zero_registers;
		test_oscillation(16'd2000, 16'd100, 2000, 150);
		test_oscillation(PERIOD_RESET, SETTLE_RESET, 10000, 100);
		test_oscillation(16'hFFFF, 16'hFFFF, 65535, 40);
		test_oscillation(16'd1, 16'd1, 400, 80);
		test_oscillation(16'd300, 16'd20, 300, 100);
		test_random_settings(4);
		test_noise(80);
		test_output_holdoff;
		test_sender_pause;
		wait_for_results;
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
design/oept_pkg.sv
design/oscillation_extremum_phase_tracker.sv
tb/oscillation_extremum_phase_tracker_tb.sv
